@@ hw/rtl/cursor_sequence_store_defines.svh @@
// ----------------------------------------------------------------------------
// cursor_sequence_store_defines
// Assertion macros of the checker file of the cursor sequence store.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_STORE_DEFINES_SVH
`define CURSOR_SEQUENCE_STORE_DEFINES_SVH

// concurrent assertion, inactive while reset is high
`define CSS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion, also checked while reset is high
`define CSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/css_pkg.sv @@
// ----------------------------------------------------------------------------
// css_pkg
// Types and constants of the cursor sequence store.
// ----------------------------------------------------------------------------
package css_pkg;

  // storage geometry
  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // operation codes of a request
  typedef enum logic [2:0] {
    FN_START   = 3'd0,
    FN_ADVANCE = 3'd1,
    FN_INSERT  = 3'd2,
    FN_ATTACH  = 3'd3,
    FN_REMOVE  = 3'd4
  } func_t;

  // error codes of a response
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_NOCUR = 2'd2
  } err_t;

  // move applied to the whole row of cells at once
  typedef enum logic [2:0] {
    SH_HOLD     = 3'd0,
    SH_ROT_UP   = 3'd1,
    SH_ROT_DOWN = 3'd2,
    SH_PUSH     = 3'd3,
    SH_POP      = 3'd4,
    SH_SWAP     = 3'd5
  } shift_t;

  // request payload
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] entry_value;
  } cmd_t;

  // response payload
  typedef struct packed {
    logic [31:0] current_value;
    logic        has_current;
    logic [6:0]  item_count;
    logic [6:0]  cursor_pos;
    logic [1:0]  error_code;
  } rsp_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    shift_t                 shift;
    logic [CNT_W-1:0]       left_cnt;
    logic [VALUE_WIDTH-1:0] value;
  } cell_ctrl_t;

  // view of the store after the last request
  typedef struct packed {
    logic             rsp_valid;
    logic             has_current;
    logic [CNT_W-1:0] item_count;
    logic [CNT_W-1:0] cursor_pos;
    err_t             error_code;
  } ctrl_status_t;

endpackage

@@ hw/rtl/css_cell.sv @@
// ----------------------------------------------------------------------------
// css_cell
// One slot of the ring. Cells from index 0 upward hold the entries from the
// cursor on (cell 0 is current); cells from the top index downward hold the
// entries before the cursor, nearest first.
// ----------------------------------------------------------------------------
module css_cell
  import css_pkg::*;
(
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [IDX_W-1:0]       idx,
  input  logic [VALUE_WIDTH-1:0] prev_val,
  input  logic [VALUE_WIDTH-1:0] next_val,
  output logic [VALUE_WIDTH-1:0] value
);

  logic [CNT_W:0]           pos_sum;
  logic                     is_head;
  logic                     in_right;
  logic                     in_swap;
  logic [VALUE_WIDTH-1:0]   value_next;

  // region of this cell relative to the entries before the cursor
  always_comb begin
    pos_sum  = (CNT_W + 1)'(idx) + (CNT_W + 1)'(ctrl.left_cnt);
    is_head  = (idx == '0);
    in_right = (pos_sum < (CNT_W + 1)'(CAPACITY));
    in_swap  = (pos_sum >= (CNT_W + 1)'(CAPACITY - 1));
  end

  // next content of the slot
  always_comb begin
    value_next = value;
    case (ctrl.shift)
      SH_ROT_UP:   value_next = prev_val;
      SH_ROT_DOWN: value_next = next_val;
      SH_PUSH: begin
        if (is_head) value_next = ctrl.value;
        else if (in_right) value_next = prev_val;
      end
      SH_POP: begin
        if (in_right) value_next = next_val;
      end
      SH_SWAP: begin
        if (is_head) value_next = ctrl.value;
        else if (in_swap) value_next = next_val;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ hw/rtl/css_ctrl.sv @@
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer: decodes requests, keeps the counts on both sides of the cursor,
// steps the rewind for start and for insert with no current entry, and holds the response flag and error code.
// ----------------------------------------------------------------------------
module css_ctrl
  import css_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  cmd_t         cmd,
  input  logic         rsp_ready,
  output cell_ctrl_t   cell_ctrl,
  output ctrl_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REWIND = 2'b10
  } state_t;

  state_t                 state, state_next;
  logic [CNT_W-1:0]       left_cnt, left_cnt_next;
  logic [CNT_W-1:0]       right_cnt, right_cnt_next;
  logic                   rsp_valid, rsp_valid_next;
  err_t                   err, err_next;
  logic                   pend_insert, pend_insert_next;
  logic [VALUE_WIDTH-1:0] pend_value, pend_value_next;
  logic [CNT_W-1:0]       count;
  logic                   accept;
  logic                   full;
  logic                   cur;

  assign count     = left_cnt + right_cnt;
  assign full      = (count == CNT_W'(CAPACITY));
  assign cur       = (right_cnt != '0);
  assign cmd_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = cmd_valid && cmd_ready;

  // request decode and rewind sequencing
  always_comb begin
    state_next         = state;
    left_cnt_next      = left_cnt;
    right_cnt_next     = right_cnt;
    rsp_valid_next     = rsp_valid && !rsp_ready;
    err_next           = err;
    pend_insert_next   = pend_insert;
    pend_value_next    = pend_value;
    cell_ctrl.shift    = SH_HOLD;
    cell_ctrl.left_cnt = left_cnt;
    cell_ctrl.value    = cmd.entry_value[VALUE_WIDTH-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          rsp_valid_next  = 1'b1;
          err_next        = ERR_NONE;
          pend_value_next = cmd.entry_value[VALUE_WIDTH-1:0];
          unique case (cmd.func)
            FN_START: begin
              if (left_cnt != '0) begin
                state_next       = ST_REWIND;
                rsp_valid_next   = 1'b0;
                pend_insert_next = 1'b0;
              end
            end
            FN_ADVANCE: begin
              if (!cur) begin
                err_next = ERR_NOCUR;
              end else begin
                cell_ctrl.shift = SH_ROT_DOWN;
                left_cnt_next   = left_cnt + CNT_W'(1);
                right_cnt_next  = right_cnt - CNT_W'(1);
              end
            end
            FN_INSERT: begin
              if (full) begin
                err_next = ERR_FULL;
              end else if (cur || left_cnt == '0) begin
                cell_ctrl.shift = SH_PUSH;
                right_cnt_next  = right_cnt + CNT_W'(1);
              end else begin
                // no current entry: bring the cursor back to the front first
                state_next       = ST_REWIND;
                rsp_valid_next   = 1'b0;
                pend_insert_next = 1'b1;
              end
            end
            FN_ATTACH: begin
              if (full) begin
                err_next = ERR_FULL;
              end else if (cur) begin
                cell_ctrl.shift = SH_SWAP;
                left_cnt_next   = left_cnt + CNT_W'(1);
              end else begin
                cell_ctrl.shift = SH_PUSH;
                right_cnt_next  = right_cnt + CNT_W'(1);
              end
            end
            FN_REMOVE: begin
              if (!cur) begin
                err_next = ERR_NOCUR;
              end else begin
                cell_ctrl.shift = SH_POP;
                right_cnt_next  = right_cnt - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_REWIND: begin
        if (left_cnt != '0) begin
          // move one entry from before the cursor to the front of the rest
          cell_ctrl.shift = SH_ROT_UP;
          left_cnt_next   = left_cnt - CNT_W'(1);
          right_cnt_next  = right_cnt + CNT_W'(1);
        end else begin
          if (pend_insert) begin
            cell_ctrl.shift = SH_PUSH;
            cell_ctrl.value = pend_value;
            right_cnt_next  = right_cnt + CNT_W'(1);
          end
          rsp_valid_next = 1'b1;
          err_next       = ERR_NONE;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      left_cnt  <= '0;
      right_cnt <= '0;
      rsp_valid <= 1'b0;
      err       <= ERR_NONE;
    end else begin
      state     <= state_next;
      left_cnt  <= left_cnt_next;
      right_cnt <= right_cnt_next;
      rsp_valid <= rsp_valid_next;
      err       <= err_next;
    end
  end

  // pending request of a rewind
  always_ff @(posedge clk) begin
    pend_insert <= pend_insert_next;
    pend_value  <= pend_value_next;
  end

  // view of the store
  always_comb begin
    status.rsp_valid   = rsp_valid;
    status.has_current = cur;
    status.item_count  = count;
    status.cursor_pos  = left_cnt;
    status.error_code  = err;
  end

endmodule

@@ hw/rtl/cursor_sequence_store.sv @@
// ----------------------------------------------------------------------------
// cursor_sequence_store
// Ordered store of up to 64 values with a cursor, held in a ring of cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (func, entry_value) is a request taken on cmd_valid && cmd_ready.
//   rsp carries the view after that request (current value, count, cursor,
//   error) and is taken on rsp_valid && rsp_ready; one response per request.
//   Every operation but two moves the whole ring at once, so the response
//   is shown in the cycle after the request and a new request can be
//   taken in each cycle while rsp_ready stays high.
//   Start, and insert with no current entry, first rotate the ring back by
//   one entry per cycle until the cursor is at the front; cmd_ready is low
//   during that rotation.
//   The response stays in place while rsp_ready is low; a new request is
//   taken in the cycle that the waiting response is taken.
//   Reset empties the store (count 0, cursor 0) at once and drops any
//   waiting response; cell contents need no clearing.
// ----------------------------------------------------------------------------
module cursor_sequence_store
  import css_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cell_ctrl_t             cell_ctrl;
  ctrl_status_t           status;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];

  // sequencer
  css_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_ready (rsp_ready),
    .cell_ctrl (cell_ctrl),
    .status    (status)
  );

  // ring of cells, each wired to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int PREV_I = (i + CAPACITY - 1) % CAPACITY;
    localparam int NEXT_I = (i + 1) % CAPACITY;
    css_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .idx      (IDX_W'(i)),
      .prev_val (cell_val[PREV_I]),
      .next_val (cell_val[NEXT_I]),
      .value    (cell_val[i])
    );
  end

  // response view, cell 0 holds the current entry
  always_comb begin
    rsp_valid         = status.rsp_valid;
    rsp.current_value = status.has_current ? 32'(cell_val[0]) : 32'd0;
    rsp.has_current   = status.has_current;
    rsp.item_count    = 7'(status.item_count);
    rsp.cursor_pos    = 7'(status.cursor_pos);
    rsp.error_code    = status.error_code;
  end

endmodule

@@ hw/rtl/css_checker.sv @@
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks of the cursor sequence store, bound to the top level.
// ----------------------------------------------------------------------------
`include "cursor_sequence_store_defines.svh"

module css_checker
  import css_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // a stalled response holds
  `CSS_ASSERT(a_rsp_hold, clk, rst,
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp),
    "response changed while stalled")

  // cursor never passes the count, count never passes capacity
  `CSS_ASSERT(a_bounds, clk, rst,
    rsp_valid |-> (rsp.cursor_pos <= rsp.item_count) &&
                  (rsp.item_count <= 7'(CAPACITY)),
    "cursor or count out of range")

  // current entry exists exactly when the cursor is before the end
  `CSS_ASSERT(a_has_cur, clk, rst,
    rsp_valid |-> (rsp.has_current == (rsp.cursor_pos != rsp.item_count)) &&
                  (rsp.has_current || rsp.current_value == 32'd0),
    "current entry flag inconsistent")

  // store-full error only with a full store
  `CSS_ASSERT(a_full, clk, rst,
    rsp_valid && rsp.error_code == ERR_FULL |-> rsp.item_count == 7'(CAPACITY),
    "full error on a store with room")

  // reset drops any response
  `CSS_ASSERT_ALWAYS(a_reset, clk, rst |=> !rsp_valid, "response present after reset")

endmodule

bind cursor_sequence_store css_checker u_css_checker (.*);
